// ===== hdl/tsn_pkg.sv =====
package tsn_pkg;

  // Texel store geometry
  localparam int MAX_TEXELS  = 65536;
  localparam int TEXEL_BYTES = 4;
  localparam int TEXEL_W     = 8 * TEXEL_BYTES;
  localparam int ADDR_W      = $clog2(MAX_TEXELS);

  // Request and result field widths
  localparam int TADDR_W = 16;
  localparam int COORD_W = 16;
  localparam int CHAN_W  = 16;
  localparam int ALPHA_W = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int SIZE_W     = 9;

  // Q1.15 one, largest texture side
  localparam logic [COORD_W-1:0] COORD_ONE = 16'h8000;
  localparam logic [SIZE_W-1:0]  SIZE_MAX  = 9'd256;

  // Shared multiply-add unit widths
  localparam int OPA_W = 16;
  localparam int OPB_W = 9;
  localparam int ACC_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_MODE = 2'd0,
    CFG_TEX_WIDTH   = 2'd1,
    CFG_TEX_HEIGHT  = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    REQ_WRITE  = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_mode_e;

  typedef enum logic {
    FILT_NEAREST  = 1'b0,
    FILT_BILINEAR = 1'b1
  } filt_mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PX,
    S_PY,
    S_ADDR,
    S_LOAD,
    S_BLEND,
    S_OUT
  } state_e;

endpackage

// ===== hdl/texture_sampler_nearest_bilinear.sv =====
// RGBA texture sampler with nearest or bilinear filtering. A request with
// mode 0 writes one 32-bit texel into the 64K-entry texel memory and gives
// no result; texels hold red in the low byte and alpha in the high byte,
// and a texel must be written before any sample reads it. A request with
// mode 1 samples at (u,v) in Q1.15 (clamped to 1.0, v = 1.0 is the top row)
// and returns red, green and blue in unsigned 8.8 plus the alpha byte of the
// base texel. All arithmetic runs through one 16x9 multiply-add unit and the
// memory has one read port, so a sample steps through the accepting state,
// 2 coordinate products, up to 4 address/fetch pairs (one per corner; a
// nearest sample fetches only the first), 18 blend steps (bilinear only)
// and the result state, which holds while the result is stalled. The input
// stalls for the whole sample.
// Configuration (filter mode, width, height) is written through the cfg
// channel, which is always ready, and must only change while the block is
// idle. There is no clearing pass after reset.
module texture_sampler_nearest_bilinear (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic [tsn_pkg::TADDR_W-1:0]   texel_addr_i,
  input  logic [tsn_pkg::TEXEL_W-1:0]   texel_rgba_i,
  input  logic [tsn_pkg::COORD_W-1:0]   u_coord_i,
  input  logic [tsn_pkg::COORD_W-1:0]   v_coord_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tsn_pkg::CHAN_W-1:0]    red_o,
  output logic [tsn_pkg::CHAN_W-1:0]    green_o,
  output logic [tsn_pkg::CHAN_W-1:0]    blue_o,
  output logic [tsn_pkg::ALPHA_W-1:0]   alpha_o,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tsn_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tsn_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tsn_pkg::*;

  // Byte c of a texel
  function automatic logic [7:0] chan_byte(logic [TEXEL_W-1:0] t, logic [1:0] c);
    logic [7:0] b;
    case (c)
      2'd0:    b = t[7:0];
      2'd1:    b = t[15:8];
      2'd2:    b = t[23:16];
      default: b = t[31:24];
    endcase
    return b;
  endfunction

  // Force a programmed size into 1..256
  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    if (s == '0) begin
      r = SIZE_W'(1);
    end else if (s > SIZE_MAX) begin
      r = SIZE_MAX;
    end else begin
      r = s;
    end
    return r;
  endfunction

  // Configuration registers
  logic                 filter_mode_q;
  logic [SIZE_W-1:0]    tex_width_q;
  logic [SIZE_W-1:0]    tex_height_q;

  // Sequencer
  state_e               state_q, state_d;
  logic [2:0]           step_q;
  logic [1:0]           chan_q;

  // Datapath registers
  logic [COORD_W-1:0]   u_q, v_q;
  logic [22:0]          px_q, py_q;
  logic [ACC_W-1:0]     acc_q;
  logic [15:0]          top_q;
  logic [TEXEL_W-1:0]   rd_q;
  logic [TEXEL_W-1:0]   tex_q [4];
  logic [CHAN_W-1:0]    res_q [3];

  // Texel memory, no reset
  logic [TEXEL_W-1:0]   mem_q [MAX_TEXELS];

  // Derived geometry
  logic [SIZE_W-1:0]    w_c, h_c;
  logic [7:0]           w_m1, h_m1;
  logic [7:0]           x0, y0, x1, y1, fx, fy;
  logic [OPB_W-1:0]     fx_inv, fy_inv;

  // Shared multiply-add unit
  logic [OPA_W-1:0]     op_a;
  logic [OPB_W-1:0]     op_b;
  logic [ACC_W-1:0]     op_c;
  logic [ACC_W-1:0]     mac;

  logic                 in_acc, out_acc, mem_we;
  logic [ADDR_W-1:0]    waddr, raddr;
  logic [7:0]           ysel, xsel;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  assign w_c  = clamp_size(tex_width_q);
  assign h_c  = clamp_size(tex_height_q);
  assign w_m1 = 8'(w_c - SIZE_W'(1));
  assign h_m1 = 8'(h_c - SIZE_W'(1));

  // u <= 1.0 keeps the integer part at or below the last column/row
  assign x0 = px_q[22:15];
  assign y0 = py_q[22:15];
  assign fx = px_q[14:7];
  assign fy = py_q[14:7];
  assign x1 = (SIZE_W'(x0) + SIZE_W'(1) >= w_c) ? w_m1 : 8'(x0 + 8'd1);
  assign y1 = (SIZE_W'(y0) + SIZE_W'(1) >= h_c) ? h_m1 : 8'(y0 + 8'd1);
  assign fx_inv = SIZE_MAX - OPB_W'(fx);
  assign fy_inv = SIZE_MAX - OPB_W'(fy);

  assign mac = ACC_W'(25'(op_a) * 25'(op_b) + 25'(op_c));

  // Corner order: top-left, top-right, bottom-left, bottom-right
  always_comb begin
    case (step_q[1:0])
      2'd0:    begin xsel = x0; ysel = y0; end
      2'd1:    begin xsel = x1; ysel = y0; end
      2'd2:    begin xsel = x0; ysel = y1; end
      default: begin xsel = x1; ysel = y1; end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && mode_i == REQ_SAMPLE) state_d = S_PX;
      end
      S_PX:   state_d = S_PY;
      S_PY:   state_d = S_ADDR;
      S_ADDR: state_d = S_LOAD;
      S_LOAD: begin
        if (filter_mode_q == FILT_NEAREST) begin
          state_d = S_OUT;
        end else if (step_q == 3'd3) begin
          state_d = S_BLEND;
        end else begin
          state_d = S_ADDR;
        end
      end
      S_BLEND: begin
        if (step_q == 3'd5 && chan_q == 2'd2) state_d = S_OUT;
      end
      S_OUT: begin
        if (out_acc) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs and multiply-add operand select
  always_comb begin
    in_stall_o  = (state_q != S_IDLE);
    out_valid_o = (state_q == S_OUT);
    cfg_ready_o = 1'b1;
    op_a = '0;
    op_b = '0;
    op_c = '0;
    case (state_q)
      S_PX: begin
        op_a = u_q;
        op_b = OPB_W'(w_m1);
      end
      S_PY: begin
        op_a = COORD_ONE - v_q;
        op_b = OPB_W'(h_m1);
      end
      S_ADDR: begin
        op_a = OPA_W'(ysel);
        op_b = w_c;
        op_c = ACC_W'(xsel);
      end
      S_BLEND: begin
        case (step_q)
          3'd0: begin
            op_a = OPA_W'(chan_byte(tex_q[0], chan_q));
            op_b = fx_inv;
          end
          3'd1: begin
            op_a = OPA_W'(chan_byte(tex_q[1], chan_q));
            op_b = OPB_W'(fx);
            op_c = acc_q;
          end
          3'd2: begin
            op_a = OPA_W'(chan_byte(tex_q[2], chan_q));
            op_b = fx_inv;
          end
          3'd3: begin
            op_a = OPA_W'(chan_byte(tex_q[3], chan_q));
            op_b = OPB_W'(fx);
            op_c = acc_q;
          end
          3'd4: begin
            // bottom row sum sits in the accumulator
            op_a = acc_q[15:0];
            op_b = OPB_W'(fy);
          end
          default: begin
            op_a = top_q;
            op_b = fy_inv;
            op_c = acc_q;
          end
        endcase
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      step_q        <= '0;
      chan_q        <= '0;
      filter_mode_q <= FILT_NEAREST;
      tex_width_q   <= SIZE_MAX;
      tex_height_q  <= SIZE_MAX;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_FILTER_MODE: filter_mode_q <= cfg_data_i[0];
          CFG_TEX_WIDTH:   tex_width_q   <= cfg_data_i;
          CFG_TEX_HEIGHT:  tex_height_q  <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        S_PY: step_q <= '0;
        S_LOAD: begin
          // advance to the next corner, or start the blend on red
          step_q <= (step_q == 3'd3) ? 3'd0 : 3'(step_q + 3'd1);
          chan_q <= '0;
        end
        S_BLEND: begin
          if (step_q == 3'd5) begin
            step_q <= '0;
            chan_q <= 2'(chan_q + 2'd1);
          end else begin
            step_q <= 3'(step_q + 3'd1);
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          u_q <= (u_coord_i > COORD_ONE) ? COORD_ONE : u_coord_i;
          v_q <= (v_coord_i > COORD_ONE) ? COORD_ONE : v_coord_i;
        end
      end
      S_PX: px_q <= mac[22:0];
      S_PY: py_q <= mac[22:0];
      S_LOAD: begin
        tex_q[step_q[1:0]] <= rd_q;
        if (filter_mode_q == FILT_NEAREST) begin
          res_q[0] <= {chan_byte(rd_q, 2'd0), 8'h00};
          res_q[1] <= {chan_byte(rd_q, 2'd1), 8'h00};
          res_q[2] <= {chan_byte(rd_q, 2'd2), 8'h00};
        end
      end
      S_BLEND: begin
        acc_q <= mac;
        if (step_q == 3'd1) top_q <= mac[15:0];
        if (step_q == 3'd5) res_q[chan_q] <= mac[23:8];
      end
      default: ;
    endcase
  end

  // Texel memory: write in idle, read one corner per address step
  assign mem_we = in_acc && mode_i == REQ_WRITE && 32'(texel_addr_i) < MAX_TEXELS;
  assign waddr  = ADDR_W'(texel_addr_i);
  assign raddr  = mac[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[waddr] <= texel_rgba_i;
    rd_q <= mem_q[raddr];
  end

  assign red_o   = res_q[0];
  assign green_o = res_q[1];
  assign blue_o  = res_q[2];
  assign alpha_o = tex_q[0][31:24];

endmodule

// ===== hdl/tsn_checker.sv =====
module tsn_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          mode_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [tsn_pkg::CHAN_W-1:0]    red_o,
  input logic [tsn_pkg::CHAN_W-1:0]    green_o,
  input logic [tsn_pkg::CHAN_W-1:0]    blue_o,
  input logic [tsn_pkg::ALPHA_W-1:0]   alpha_o
);
  import tsn_pkg::*;

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(red_o) && $stable(green_o)
      && $stable(blue_o) && $stable(alpha_o))
    else $error("stalled result changed");

  // A sample request keeps the block busy and gives no result the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && mode_i == REQ_SAMPLE |=> in_stall_o && !out_valid_o)
    else $error("sample request not held busy");

  // A write request produces no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && mode_i == REQ_WRITE |=> !out_valid_o)
    else $error("write request produced a result");

  // No new request while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request taken while result pending");

  // Channels stay within 255.0 in 8.8
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> red_o <= 16'hFF00 && green_o <= 16'hFF00 && blue_o <= 16'hFF00)
    else $error("channel out of range");

endmodule

bind texture_sampler_nearest_bilinear tsn_checker u_tsn_checker (.*);
